// ===== sv/hss_pkg.sv =====
// ----------------------------------------------------------------------------
// hss_pkg
// Shared widths, command codes, coil pattern table and control and status
// structs for the six-axis half-step sequencer.
// ----------------------------------------------------------------------------
package hss_pkg;

    localparam int CMD_W       = 2;
    localparam int IDX_W       = 3;
    localparam int STEP_W      = 16;
    localparam int COIL_W      = 24;
    localparam int BUSY_W      = 6;
    localparam int PHASE_W     = 3;
    localparam int NIBBLE_W    = 4;

    localparam int NUM_MOTORS_DEF  = 6;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_JOG  = 2'd2;

    typedef struct packed {
        logic tick;
        logic load;
        logic jog;
        logic dir;
    } motor_ctrl_t;

    typedef struct packed {
        logic [NIBBLE_W-1:0] nibble;
        logic                busy;
        logic                rejected;
    } motor_status_t;

    function automatic logic [NIBBLE_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [NIBBLE_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'b1000;
            3'd1:    pat = 4'b1010;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b0101;
            3'd6:    pat = 4'b0001;
            3'd7:    pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

// ===== sv/hss_item_if.sv =====
// ----------------------------------------------------------------------------
// hss_item_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface hss_item_if;
    import hss_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   motor_index;
    logic               direction;
    logic [STEP_W-1:0]  step_count;

    modport source (output valid, output command, output motor_index,
                    output direction, output step_count, input ready);
    modport sink   (input valid, input command, input motor_index,
                    input direction, input step_count, output ready);
endinterface

// ===== sv/hss_result_if.sv =====
// ----------------------------------------------------------------------------
// hss_result_if
// Result channel: valid/ready handshake carrying coil word and status.
// ----------------------------------------------------------------------------
interface hss_result_if;
    import hss_pkg::*;

    logic               valid;
    logic               ready;
    logic [COIL_W-1:0]  coil_drive;
    logic [BUSY_W-1:0]  busy_mask;
    logic               load_rejected;

    modport source (output valid, output coil_drive, output busy_mask,
                    output load_rejected, input ready);
    modport sink   (input valid, input coil_drive, input busy_mask,
                    input load_rejected, output ready);
endinterface

// ===== sv/six_axis_half_step_sequencer.sv =====
// ----------------------------------------------------------------------------
// six_axis_half_step_sequencer
// Half-step coil sequencer for six bipolar stepper motors.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result stage is not stalled: each item
// is registered on entry, then the motor channels update in parallel and
// write the result register once the result stage is free. A tick drives
// each running motor's current coil pattern on its nibble of coil_drive
// (motor 0 lowest) and steps its phase; each phase wrap takes one from its
// cycle count. Load arms an idle motor and is flagged as rejected on a
// running one; jog sets the direction and arms an idle motor with a count
// of one. coil_drive holds between ticks. A stalled result stage holds the
// entry register, which then backs up the item channel.
// ----------------------------------------------------------------------------
module six_axis_half_step_sequencer #(
    parameter int NUM_MOTORS  = hss_pkg::NUM_MOTORS_DEF,
    parameter int COUNT_WIDTH = hss_pkg::COUNT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    hss_item_if.sink      item,
    hss_result_if.source  result
);
    import hss_pkg::*;

    localparam int WORD_W = NIBBLE_W * NUM_MOTORS;

    logic                    in_valid_reg;
    logic [CMD_W-1:0]        command_reg;
    logic [IDX_W-1:0]        motor_index_reg;
    logic                    direction_reg;
    logic [STEP_W-1:0]       step_count_reg;

    logic                    out_valid_reg;
    logic [COIL_W-1:0]       coil_reg, coil_next;
    logic [BUSY_W-1:0]       busy_reg, busy_next;
    logic                    rejected_reg, rejected_next;

    logic                    advance;
    logic [COUNT_WIDTH-1:0]  load_count;
    motor_ctrl_t             ctrl   [NUM_MOTORS];
    motor_status_t           status [NUM_MOTORS];
    logic [WORD_W-1:0]       word;
    logic [NUM_MOTORS-1:0]   busy_vec;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign load_count = COUNT_WIDTH'(step_count_reg);

    always_comb
    begin
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            ctrl[m].tick = advance && (command_reg == CMD_TICK);
            ctrl[m].load = advance && (command_reg == CMD_LOAD)
                           && (motor_index_reg == IDX_W'(m));
            ctrl[m].jog  = advance && (command_reg == CMD_JOG)
                           && (motor_index_reg == IDX_W'(m));
            ctrl[m].dir  = direction_reg;
        end
    end

    for (genvar g = 0; g < NUM_MOTORS; g++)
    begin : g_motor
        hss_motor #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_motor (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl[g]),
            .load_count (load_count),
            .status     (status[g])
        );
    end

    always_comb
    begin
        rejected_next = 1'b0;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            word[NIBBLE_W*m +: NIBBLE_W] = status[m].nibble;
            busy_vec[m]                  = status[m].busy;
            rejected_next                = rejected_next | status[m].rejected;
        end
        busy_next = BUSY_W'(busy_vec);
        coil_next = (command_reg == CMD_TICK) ? COIL_W'(word) : coil_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            coil_reg      <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                coil_reg      <= coil_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            command_reg     <= item.command;
            motor_index_reg <= item.motor_index;
            direction_reg   <= item.direction;
            step_count_reg  <= item.step_count;
        end
        if (advance)
        begin
            busy_reg     <= busy_next;
            rejected_reg <= rejected_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.coil_drive    = coil_reg;
    assign result.busy_mask     = busy_reg;
    assign result.load_rejected = rejected_reg;

endmodule

// ===== sv/hss_motor.sv =====
// ----------------------------------------------------------------------------
// hss_motor
// One motor channel: cycle count, direction and phase with tick, load and
// jog update, coil nibble and busy/reject status.
// ----------------------------------------------------------------------------
module hss_motor #(
    parameter int COUNT_WIDTH = hss_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hss_pkg::motor_ctrl_t   ctrl,
    input  logic [COUNT_WIDTH-1:0] load_count,
    output hss_pkg::motor_status_t status
);
    import hss_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   dir_reg, dir_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic                   active;

    assign active = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        dir_next   = dir_reg;
        phase_next = phase_reg;
        if (ctrl.tick && active)
        begin
            if (dir_reg)
            begin
                phase_next = phase_reg + PHASE_W'(1);
                if (phase_reg == '1)
                begin
                    count_next = count_reg - COUNT_WIDTH'(1);
                end
            end
            else
            begin
                phase_next = phase_reg - PHASE_W'(1);
                if (phase_reg == '0)
                begin
                    count_next = count_reg - COUNT_WIDTH'(1);
                end
            end
        end
        else if (ctrl.load && !active)
        begin
            count_next = load_count;
            dir_next   = ctrl.dir;
        end
        else if (ctrl.jog)
        begin
            if (!active)
            begin
                count_next = COUNT_WIDTH'(1);
            end
            dir_next = ctrl.dir;
        end
    end

    assign status.nibble   = (ctrl.tick && active) ? coil_pattern(phase_reg) : '0;
    assign status.busy     = (count_next != '0);
    assign status.rejected = ctrl.load && active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dir_reg   <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            dir_reg   <= dir_next;
            phase_reg <= phase_next;
        end
    end

    a_tick_up_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.tick && active && dir_reg |=> phase_reg == $past(phase_reg) + PHASE_W'(1))
        else $error("phase did not advance on up tick");

    a_tick_no_count_rise: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.tick |=> count_reg <= $past(count_reg))
        else $error("count rose on tick");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load && active |=> count_reg == $past(count_reg) && dir_reg == $past(dir_reg))
        else $error("rejected load changed motor state");

    a_jog_sets: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.jog |=> dir_reg == $past(ctrl.dir) && count_reg != '0)
        else $error("jog did not arm motor");

endmodule

// ===== tb/sv/six_axis_half_step_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// six_axis_half_step_sequencer_tb
// Self-checking regression for the six-axis half-step sequencer.
// A short table of directed items covers reset, ignored and unused commands,
// rejected loads and both phase wraps. A long random run of ticks, loads,
// jogs and unused commands follows. Each result is checked with the table or
// an in-bench motor model as both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module six_axis_half_step_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hss_pkg::*;

    localparam int MOTORS        = NUM_MOTORS_DEF;
    localparam int RANDOM_ITEMS  = 850;
    localparam int CALM_ITEMS    = 150;
    localparam int DIRECTED_ROWS = 25;
    localparam int WATCHDOG_MAX  = 500;
    localparam int DRAIN_CYCLES  = 10;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic [NIBBLE_W-1:0] HALF_STEP_COILS [8] =
        '{4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9};

    typedef struct packed {
        logic [COIL_W-1:0] coil;
        logic [BUSY_W-1:0] busy;
        logic              rejected;
    } coil_status_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  motor;
        logic              dir;
        logic [STEP_W-1:0] count;
        logic              typed;
        logic [COIL_W-1:0] coil;
        logic [BUSY_W-1:0] busy;
        logic              rej;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_TICK,  3'd0, 1'b0, 16'h0000, 1'b1, 24'h000000, 6'h00, 1'b0},
        '{CMD_SPARE, 3'd7, 1'b1, 16'hFFFF, 1'b1, 24'h000000, 6'h00, 1'b0},
        '{CMD_LOAD,  3'd6, 1'b1, 16'hFFFF, 1'b1, 24'h000000, 6'h00, 1'b0},
        '{CMD_JOG,   3'd7, 1'b0, 16'h0000, 1'b1, 24'h000000, 6'h00, 1'b0},
        '{CMD_LOAD,  3'd0, 1'b1, 16'h0000, 1'b1, 24'h000000, 6'h00, 1'b0},
        '{CMD_LOAD,  3'd5, 1'b1, 16'h0001, 1'b1, 24'h000000, 6'h20, 1'b0},
        '{CMD_LOAD,  3'd5, 1'b0, 16'hFFFF, 1'b1, 24'h000000, 6'h20, 1'b1},
        '{CMD_JOG,   3'd0, 1'b0, 16'h0000, 1'b1, 24'h000000, 6'h21, 1'b0},
        '{CMD_TICK,  3'd0, 1'b0, 16'h0000, 1'b1, 24'h800008, 6'h20, 1'b0},
        '{CMD_JOG,   3'd0, 1'b1, 16'h0000, 1'b1, 24'h800008, 6'h21, 1'b0},
        '{CMD_TICK,  3'd0, 1'b0, 16'h0000, 1'b1, 24'hA00009, 6'h20, 1'b0},
        '{CMD_LOAD,  3'd1, 1'b0, 16'h0002, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_JOG,   3'd5, 1'b0, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd1, 1'b1, 16'h5555, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd2, 1'b0, 16'hAAAA, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd3, 1'b1, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd4, 1'b0, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd5, 1'b1, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd6, 1'b0, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd7, 1'b1, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_LOAD,  3'd2, 1'b1, 16'h0003, 1'b0, 24'h000000, 6'h00, 1'b0},
        '{CMD_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, 24'h000000, 6'h00, 1'b0}
    };

    logic clk;
    logic rst_n;

    hss_item_if   item_ch ();
    hss_result_if result_ch ();

    six_axis_half_step_sequencer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    logic [STEP_W-1:0]  motor_cycles [MOTORS];
    logic               motor_dir    [MOTORS];
    logic [PHASE_W-1:0] motor_phase  [MOTORS];
    logic [COIL_W-1:0]  held_coil;

    coil_status_t coil_status_q [$];

    int  errors;
    int  items_sent;
    int  results_checked;
    int  loads_rejected;
    int  ticks_sent;
    int  idle_cycles;
    int  send_gap_pct;
    int  stall_pct;
    bit  calm;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic coil_status_t step_motors(input logic [CMD_W-1:0] cmd,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic dir,
                                                 input logic [STEP_W-1:0] cnt);
        coil_status_t      status;
        logic [COIL_W-1:0] word;
        bit                addressed;
        int                m;
        status    = '0;
        addressed = idx < MOTORS;
        case (cmd)
            CMD_TICK:
            begin
                word = '0;
                for (m = 0; m < MOTORS; m++)
                begin
                    if (motor_cycles[m] != 0)
                    begin
                        word[4*m +: 4] = HALF_STEP_COILS[motor_phase[m]];
                        if (motor_dir[m])
                        begin
                            if (motor_phase[m] == 3'd7)
                                motor_cycles[m] = motor_cycles[m] - 1'b1;
                            motor_phase[m] = motor_phase[m] + 1'b1;
                        end
                        else
                        begin
                            if (motor_phase[m] == 3'd0)
                                motor_cycles[m] = motor_cycles[m] - 1'b1;
                            motor_phase[m] = motor_phase[m] - 1'b1;
                        end
                    end
                end
                held_coil = word;
            end
            CMD_LOAD:
            begin
                if (addressed)
                begin
                    if (motor_cycles[idx] != 0)
                        status.rejected = 1'b1;
                    else
                    begin
                        motor_cycles[idx] = cnt;
                        motor_dir[idx]    = dir;
                    end
                end
            end
            CMD_JOG:
            begin
                if (addressed)
                begin
                    if (motor_cycles[idx] == 0)
                        motor_cycles[idx] = STEP_W'(1);
                    motor_dir[idx] = dir;
                end
            end
            default:
            begin
            end
        endcase
        for (m = 0; m < MOTORS; m++)
            status.busy[m] = motor_cycles[m] != 0;
        status.coil = held_coil;
        return status;
    endfunction

    task automatic send_item(input stim_row_t row);
        coil_status_t predicted;
        if (!calm && $urandom_range(0, 99) < send_gap_pct)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= row.command;
        item_ch.motor_index <= row.motor;
        item_ch.direction   <= row.dir;
        item_ch.step_count  <= row.count;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = step_motors(row.command, row.motor, row.dir, row.count);
        if (row.typed)
            coil_status_q.push_back(coil_status_t'{row.coil, row.busy, row.rej});
        else
            coil_status_q.push_back(predicted);
        items_sent++;
        if (predicted.rejected)
            loads_rejected++;
        if (row.command == CMD_TICK)
            ticks_sent++;
        @(negedge clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_motor();
        if ($urandom_range(0, 15) == 0)
            return IDX_W'($urandom_range(MOTORS, 7));
        return IDX_W'($urandom_range(0, MOTORS - 1));
    endfunction

    always @(posedge clk)
    begin
        coil_status_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_checked++;
            if (coil_status_q.size() == 0)
            begin
                $error("result with nothing expected: coil_drive %h", result_ch.coil_drive);
                errors++;
            end
            else
            begin
                want = coil_status_q.pop_front();
                if (result_ch.coil_drive !== want.coil)
                begin
                    $error("coil_drive: expected %h, got %h", want.coil, result_ch.coil_drive);
                    errors++;
                end
                if (result_ch.busy_mask !== want.busy)
                begin
                    $error("busy_mask: expected %h, got %h", want.busy, result_ch.busy_mask);
                    errors++;
                end
                if (result_ch.load_rejected !== want.rejected)
                begin
                    $error("load_rejected: expected %b, got %b",
                           want.rejected, result_ch.load_rejected);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("timeout: %0d results still expected", coil_status_q.size());
            $display("six_axis_half_step_sequencer regression: fail");
            $finish;
        end
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        stim_row_t row;
        int        counted;
        int        pick;
        int        k;
        bit        ignored;
        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.command     <= CMD_TICK;
        item_ch.motor_index <= '0;
        item_ch.direction   <= 1'b0;
        item_ch.step_count  <= '0;
        errors          = 0;
        items_sent      = 0;
        results_checked = 0;
        loads_rejected  = 0;
        ticks_sent      = 0;
        send_gap_pct    = 20;
        stall_pct       = 20;
        calm            = 1'b0;
        held_coil       = '0;
        for (k = 0; k < MOTORS; k++)
        begin
            motor_cycles[k] = '0;
            motor_dir[k]    = 1'b0;
            motor_phase[k]  = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
            send_item(DIRECTED[k]);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 120 == 0)
            begin
                send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
                stall_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            end
            calm          = counted >= RANDOM_ITEMS - CALM_ITEMS;
            row           = '0;
            row.dir       = 1'($urandom_range(0, 1));
            row.motor     = pick_motor();
            row.count     = STEP_W'($urandom());
            pick          = $urandom_range(0, 99);
            if (pick < 52)
                row.command = CMD_TICK;
            else if (pick < 77)
            begin
                row.command = CMD_LOAD;
                if (row.motor < MOTORS && motor_cycles[row.motor] == 0)
                begin
                    if ($urandom_range(0, 29) == 0)
                        row.count = STEP_W'($urandom_range(4, 40));
                    else
                        row.count = STEP_W'($urandom_range(0, 3));
                end
            end
            else if (pick < 94)
                row.command = CMD_JOG;
            else
                row.command = CMD_SPARE;
            ignored = row.command == CMD_SPARE ||
                      (row.command != CMD_TICK && row.motor >= MOTORS);
            send_item(row);
            if (!ignored)
                counted++;
        end
        item_ch.valid <= 1'b0;

        while (coil_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent (%0d directed, %0d ticks), %0d results checked",
                 items_sent, DIRECTED_ROWS, ticks_sent, results_checked);
        $display("%0d loads rejected on running motors, %0d mismatches",
                 loads_rejected, errors);
        if (errors == 0)
            $display("six_axis_half_step_sequencer regression: pass");
        else
            $display("six_axis_half_step_sequencer regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/hss_pkg.sv
sv/hss_item_if.sv
sv/hss_result_if.sv
sv/hss_motor.sv
sv/six_axis_half_step_sequencer.sv
tb/sv/six_axis_half_step_sequencer_tb.sv
